// ===== rtl/bitmap_block_allocator_unit_defines.svh =====
// Assertion macros shared by the bitmap block allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bitmap allocator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bitmap allocator assertion failed");

`endif

// ===== rtl/bba_pkg.sv =====
// Package of the bitmap block allocator: sizes, request and status codes,
// and the command and status structs between controller and datapath.
package bba_pkg;

	localparam int WORD_COUNT = 64;
	localparam int BIT_W      = 6;
	localparam int WORD_BITS  = 1 << BIT_W;
	localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int REL_W      = ADDR_W + BIT_W;
	localparam int CAPACITY   = WORD_COUNT * WORD_BITS;
	localparam int NUM_W      = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		KIND_GET   = 2'd0,
		KIND_SET   = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_FIND  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    rd_value;
		logic    scan_start;
		logic    scan_next;
		logic    commit_access;
		logic    commit_find;
		logic    res_set;
		status_t res_code;
		logic    out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		kind_t kind;
		logic  in_range;
		logic  find_empty;
		logic  hit;
		logic  last_word;
		logic  out_free;
	} sts_t;

endpackage

// ===== rtl/bba_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on bba_pkg for the field widths.
interface bba_req_if import bba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [NUM_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             bit_res;
	logic [NUM_W-1:0] found_value;
	logic [1:0]       status;

	modport source (output valid, output bit_res, output found_value, output status,
		input ready);
	modport sink (input valid, input bit_res, input found_value, input status,
		output ready);
endinterface

// ===== rtl/bba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/bba_ctrl.sv =====
// Controller of the bitmap block allocator: sequences one request at a time.
// Depends on bba_pkg for the command and status structs.
module bba_ctrl import bba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ACCESS,
		ST_SCAN,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		cmd      = '0;
		cmd.res_code = STATUS_OK;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.kind == KIND_FIND) begin
					if (sts.find_empty) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = STATUS_FULL;
						state_d      = ST_RESP;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
				end else if (!sts.in_range) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = STATUS_RANGE;
					state_d      = ST_RESP;
				end else begin
					cmd.rd_value = 1'b1;
					state_d      = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				cmd.commit_access = 1'b1;
				state_d           = ST_RESP;
			end
			ST_SCAN: begin
				if (sts.hit) begin
					cmd.commit_find = 1'b1;
					state_d         = ST_RESP;
				end else if (sts.last_word) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = STATUS_FULL;
					state_d      = ST_RESP;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/bba_datapath.sv =====
// Datapath of the bitmap block allocator: range registers, bitmap RAM with
// valid bits, search cursor, word scan and the result register.
// Depends on bba_pkg, bba_ram and the assertion macro header.
`include "bitmap_block_allocator_unit_defines.svh"

module bba_datapath import bba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NUM_W-1:0]     cfg_data,
	input  logic [1:0]           req_kind,
	input  logic [NUM_W-1:0]     req_value,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_bit,
	output logic [NUM_W-1:0]     out_found,
	output logic [1:0]           out_status
);

	logic [NUM_W-1:0]     low_q;
	logic [NUM_W-1:0]     high_q;
	kind_t                kind_q;
	logic [NUM_W-1:0]     value_q;
	logic [ADDR_W-1:0]    cursor_q;
	logic [ADDR_W-1:0]    scan_q;
	logic                 valid_q [WORD_COUNT];
	logic                 rd_vld_q;
	logic                 res_bit_q;
	logic [NUM_W-1:0]     res_found_q;
	status_t              res_status_q;
	logic                 out_valid_q;
	logic                 out_bit_q;
	logic [NUM_W-1:0]     out_found_q;
	status_t              out_status_q;

	logic [NUM_W:0]       limit;
	logic [NUM_W:0]       top_ext;
	logic [NUM_W-1:0]     top;
	logic [NUM_W-1:0]     top_rel_full;
	logic [REL_W-1:0]     top_rel;
	logic [ADDR_W-1:0]    last_word;
	logic [NUM_W-1:0]     x_rel_full;
	logic [ADDR_W-1:0]    acc_word;
	logic [BIT_W-1:0]     acc_bit;
	logic [WORD_BITS-1:0] acc_mask;
	logic                 ram_rd_en;
	logic [ADDR_W-1:0]    ram_rd_addr;
	logic [WORD_BITS-1:0] ram_rd_data;
	logic                 ram_wr_en;
	logic [WORD_BITS-1:0] ram_wr_data;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] free_bits;
	logic                 hit;
	logic [BIT_W-1:0]     hit_bit;
	logic [NUM_W:0]       found_sum;

	// Tracked range: range_high clipped to the bitmap capacity.
	always_comb begin
		limit        = {1'b0, low_q} + (NUM_W+1)'(CAPACITY - 1);
		top_ext      = ({1'b0, high_q} < limit) ? {1'b0, high_q} : limit;
		top          = top_ext[NUM_W-1:0];
		top_rel_full = top - low_q;
		top_rel      = top_rel_full[REL_W-1:0];
		last_word    = top_rel[REL_W-1:BIT_W];
		x_rel_full   = value_q - low_q;
		acc_word     = x_rel_full[REL_W-1:BIT_W];
		acc_bit      = x_rel_full[BIT_W-1:0];
		acc_mask     = WORD_BITS'(1) << acc_bit;
	end

	// Word as read; an entry never written reads as all free.
	assign word = rd_vld_q ? ram_rd_data : '0;

	// Free bits of the scanned word, cut at the top of the range, and the
	// lowest of them.
	always_comb begin
		hit     = 1'b0;
		hit_bit = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			free_bits[b] = !word[b] &&
				((scan_q != last_word) || (BIT_W'(b) <= top_rel[BIT_W-1:0]));
		end
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				hit     = 1'b1;
				hit_bit = BIT_W'(b);
			end
		end
		found_sum = {1'b0, low_q} + (NUM_W+1)'({scan_q, hit_bit});
	end

	// Status towards the controller.
	always_comb begin
		sts.kind       = kind_q;
		sts.in_range   = (value_q >= low_q) && (value_q <= top);
		sts.find_empty = (low_q > high_q) || (cursor_q > last_word);
		sts.hit        = hit;
		sts.last_word  = (scan_q == last_word);
		sts.out_free   = !out_valid_q || out_ready;
	end

	// RAM port control.
	always_comb begin
		ram_rd_en   = cmd.rd_value || cmd.scan_start || cmd.scan_next;
		ram_rd_addr = cmd.rd_value ? acc_word :
			(cmd.scan_start ? cursor_q : scan_q + ADDR_W'(1));
		ram_wr_en   = cmd.commit_access &&
			((kind_q == KIND_SET) || (kind_q == KIND_CLEAR));
		ram_wr_data = (kind_q == KIND_SET) ? (word | acc_mask) : (word & ~acc_mask);
	end

	bba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORD_COUNT)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(acc_word),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// Configuration registers, valid bits, cursor and output flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= '0;
			high_q      <= NUM_W'(4095);
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
			for (int w = 0; w < WORD_COUNT; w++) begin
				valid_q[w] <= 1'b0;
			end
		end else begin
			if (cfg_wr_en && (cfg_index == REG_RANGE_LOW)) begin
				low_q <= cfg_data;
			end
			if (cfg_wr_en && (cfg_index == REG_RANGE_HIGH)) begin
				high_q <= cfg_data;
			end
			if (ram_wr_en) begin
				valid_q[acc_word] <= 1'b1;
			end
			if (cmd.commit_access && (kind_q == KIND_CLEAR) && (cursor_q > acc_word)) begin
				cursor_q <= acc_word;
			end else if (cmd.commit_find) begin
				cursor_q <= scan_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, scan and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind_t'(req_kind);
			value_q <= req_value;
		end
		if (ram_rd_en) begin
			rd_vld_q <= valid_q[ram_rd_addr];
		end
		if (cmd.scan_start) begin
			scan_q <= cursor_q;
		end else if (cmd.scan_next) begin
			scan_q <= scan_q + ADDR_W'(1);
		end
		if (cmd.res_set) begin
			res_bit_q    <= 1'b0;
			res_found_q  <= '0;
			res_status_q <= cmd.res_code;
		end else if (cmd.commit_access) begin
			res_bit_q    <= (kind_q == KIND_GET) ? ((word & acc_mask) != '0) : 1'b0;
			res_found_q  <= '0;
			res_status_q <= STATUS_OK;
		end else if (cmd.commit_find) begin
			res_bit_q    <= 1'b0;
			res_found_q  <= found_sum[NUM_W-1:0];
			res_status_q <= STATUS_OK;
		end
		if (cmd.out_load) begin
			out_bit_q    <= res_bit_q;
			out_found_q  <= res_found_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_bit    = out_bit_q;
	assign out_found  = out_found_q;
	assign out_status = out_status_q;

	// A waiting result is never overwritten.
	`BBA_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.out_load, !out_valid_q || out_ready)
	// The scan only moves on past a word without a free number below the top.
	`BBA_ASSERT_NOW(a_scan_next_ok, clk, arst_n, cmd.scan_next,
		!hit && (scan_q != last_word))
	// A clear never leaves the cursor beyond the freed word.
	`BBA_ASSERT_NEXT(a_clear_cursor, clk, arst_n,
		cmd.commit_access && (kind_q == KIND_CLEAR), cursor_q <= $past(acc_word))
	// A full report carries no number.
	`BBA_ASSERT_NOW(a_full_clean, clk, arst_n,
		out_valid_q && (out_status_q == STATUS_FULL), (out_found_q == '0) && !out_bit_q)

endmodule

// ===== rtl/bitmap_block_allocator_unit.sv =====
// Top level of the bitmap block allocator: joins controller and datapath.
// Depends on bba_pkg, the channel interfaces, bba_ctrl and bba_datapath.
//
// The block keeps a used/free bitmap of 64 words of 64 bits over the numbers
// range_low to range_high, all free after reset, and serves one request at a
// time. A get, set or clear goes through decode, one RAM read, and a
// read-modify-write for set and clear before its result is registered.
// A find reads one bitmap word per cycle from the search cursor upward until
// it hits a free number or has inspected the last word of the range; a find
// that can see at once that nothing is free answers straight from decode.
// The single RAM read port sets that scan rate. A new request beat is taken as
// soon as the previous one has finished, while its result may still wait in
// the output register. No clearing pass is needed after reset.
module bitmap_block_allocator_unit import bba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bba_req_if.sink              req,
	bba_rsp_if.source            rsp,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NUM_W-1:0]     cfg_data
);

	cmd_t cmd;
	sts_t sts;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bba_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_kind  (req.kind),
		.req_value (req.value),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_bit   (rsp.bit_res),
		.out_found (rsp.found_value),
		.out_status(rsp.status)
	);

endmodule
